/* src/sfcf_pkg.sv */
// sfcf_pkg: request/result payload types, register codes and fixed constants
// for the shared fragment candidate filter. No dependencies.
`default_nettype none

package sfcf_pkg;

   localparam int BIN_W    = 13;
   localparam int MAX_BINS = 4096;
   localparam int THR_W    = 4;

   localparam logic [3:0]       THRESHOLD_RESET = 4'd3;
   localparam logic [BIN_W-1:0] BIN_COUNT_RESET = 13'd2048;

   // register select is paddr bit 2 (byte addresses 0 and 4)
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_BIN_COUNT = 1'b1;

   typedef struct packed {
      logic [15:0]        candidate_tag;
      logic signed [31:0] score;
      logic [15:0]        mz_value;
      logic               end_of_candidate;
      logic               end_of_scan;
   } req_type;

   typedef struct packed {
      logic [15:0]        kept_tag;
      logic signed [31:0] kept_score;
      logic               last_kept;
      logic               overflow;
   } rsp_type;

   // commands to the overlap counter
   typedef struct packed {
      logic load;    // store a bin of the lower ranked candidate
      logic clear;   // start a new pair
      logic check;   // compare one valid bin of the higher ranked candidate
   } ov_ctrl_type;

endpackage

`default_nettype wire

/* src/sfcf_overlap.sv */
// sfcf_overlap: holds the bins of the lower ranked candidate and counts the
// distinct bins that the higher ranked one shares with it. Uses sfcf_pkg.
`default_nettype none

module sfcf_overlap #(
   parameter int MZ  = 12,
   parameter int SW  = 4,
   parameter int SIW = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire sfcf_pkg::ov_ctrl_type      ctrl,
   input  wire logic [SIW-1:0]             slot,
   input  wire logic [sfcf_pkg::BIN_W-1:0] bin,
   input  wire logic [SW-1:0]              len_b,
   output logic [SW-1:0]                   count
);

   logic [sfcf_pkg::BIN_W-1:0] breg_ff [MZ];
   logic [MZ-1:0]              marks_ff, marks_in;
   logic [SW-1:0]              count_ff, count_in;
   logic [MZ-1:0]              eq;

   always_comb begin
      for (int k = 0; k < MZ; k++) begin
         eq[k] = (breg_ff[k] == bin) && (SW'(k) < len_b);
      end
   end

   // marks dedupe on the stored side, so a repeated bin counts once
   always_comb begin
      marks_in = marks_ff;
      count_in = count_ff;
      if (ctrl.clear) begin
         marks_in = '0;
         count_in = '0;
      end else if (ctrl.check) begin
         marks_in = marks_ff | eq;
         if ((|eq) && !(|(eq & marks_ff))) begin
            count_in = count_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         breg_ff[slot] <= bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
         count_ff <= '0;
      end else begin
         marks_ff <= marks_in;
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

   property p_count_bounded;
      @(posedge clock) disable iff (reset) count_ff <= SW'(MZ);
   endproperty
   a_count_bounded: assert property (p_count_bounded) else $error("overlap count too large");

   property p_clear_zero;
      @(posedge clock) disable iff (reset) ctrl.clear |=> (count_ff == '0 && marks_ff == '0);
   endproperty
   a_clear_zero: assert property (p_clear_zero) else $error("overlap not cleared");

   property p_count_tracks_marks;
      @(posedge clock) disable iff (reset) ctrl.check && !(|eq) |=> $stable(count_ff);
   endproperty
   a_count_tracks_marks: assert property (p_count_tracks_marks)
      else $error("count moved without a hit");

endmodule

`default_nettype wire

/* src/shared_fragment_candidate_filter.sv */
// Shared fragment candidate filter: loads one request (one m/z) per cycle while
// a scan is open; at the end of scan it ranks the candidates on the score memory,
// compares each candidate with the higher ranked ones until it is dropped, and
// sends the kept ones one after another, holding while the result is stalled.
// Throughput is bounded by the single read port of each memory.
// Synchronous reset clears control state only; the stores need no clearing pass.
`default_nettype none

module shared_fragment_candidate_filter #(
   parameter int MAX_CANDIDATES   = 32,
   parameter int MZ_PER_CANDIDATE = 12
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire sfcf_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output sfcf_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [2:0]        csr_paddr,
   input  wire logic [31:0]       csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   localparam int MZ   = MZ_PER_CANDIDATE;
   localparam int NW   = $clog2(MAX_CANDIDATES + 1);
   localparam int CW   = $clog2(MAX_CANDIDATES);
   localparam int SW   = $clog2(MZ + 1);
   localparam int SIW  = (MZ > 1) ? $clog2(MZ) : 1;
   localparam int BD   = MAX_CANDIDATES * MZ;
   localparam int AW   = $clog2(BD);
   localparam int CMPW = (SW > sfcf_pkg::THR_W) ? SW : sfcf_pkg::THR_W;
   localparam int BW   = sfcf_pkg::BIN_W;

   typedef enum logic [21:0] {
      ST_LOAD     = 22'h000001,
      ST_RK_RDI   = 22'h000002,
      ST_RK_LDI   = 22'h000004,
      ST_RK_RD    = 22'h000008,
      ST_RK_CMP   = 22'h000010,
      ST_RK_WR    = 22'h000020,
      ST_DR_RB    = 22'h000040,
      ST_DR_LB    = 22'h000080,
      ST_DR_LENBR = 22'h000100,
      ST_DR_LENB  = 22'h000200,
      ST_DR_BRD   = 22'h000400,
      ST_DR_BW    = 22'h000800,
      ST_DR_RA    = 22'h001000,
      ST_DR_LA    = 22'h002000,
      ST_DR_LENAR = 22'h004000,
      ST_DR_LENA  = 22'h008000,
      ST_DR_ARD   = 22'h010000,
      ST_DR_AC    = 22'h020000,
      ST_LS       = 22'h040000,
      ST_EM_CHK   = 22'h080000,
      ST_EM_RK    = 22'h100000,
      ST_EM_TS    = 22'h200000
   } state_type;

   // memories
   logic [BW-1:0] bin_mem   [BD];
   logic [31:0]   score_mem [MAX_CANDIDATES];
   logic [15:0]   tag_mem   [MAX_CANDIDATES];
   logic [CW-1:0] rank_mem  [MAX_CANDIDATES];
   logic [SW-1:0] len_mem   [MAX_CANDIDATES];

   logic [BW-1:0] bin_rdata_ff;
   logic [31:0]   score_rdata_ff;
   logic [15:0]   tag_rdata_ff;
   logic [CW-1:0] rank_rdata_ff;
   logic [SW-1:0] len_rdata_ff;

   logic [AW-1:0] bin_raddr, bin_waddr;
   logic [CW-1:0] head_raddr, rank_raddr, len_raddr;
   logic          head_we, bin_we, len_we, rank_we;
   logic [CW-1:0] cur_idx;
   logic [BW-1:0] req_bin;

   // control and scan registers
   state_type                 state_ff, state_in;
   logic [sfcf_pkg::THR_W-1:0] thr_ff, thr_in;
   logic [BW-1:0]             binc_ff, binc_in;
   logic [NW-1:0]             cand_count_ff, cand_count_in;
   logic [SW-1:0]             slot_count_ff, slot_count_in;
   logic                      disc_ff, disc_in;
   logic                      ovf_ff, ovf_in;
   logic [MAX_CANDIDATES-1:0] drop_ff, drop_in;
   logic [CW-1:0]             ri_ff, ri_in, rk_ff, rk_in, pos_ff, pos_in;
   logic [31:0]               si_ff, si_in;
   logic [CW-1:0]             pi_ff, pi_in, pj_ff, pj_in;
   logic [CW-1:0]             cb_ff, cb_in, ca_ff, ca_in;
   logic [SW-1:0]             lenb_ff, lenb_in, lena_ff, lena_in, s_ff, s_in;
   logic [CW-1:0]             last_ff, last_in, pe_ff, pe_in, em_cand_ff, em_cand_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   sfcf_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   sfcf_pkg::ov_ctrl_type     ov_ctrl;
   logic [SW-1:0]             ov_count;
   logic [CW-1:0]             n_last;
   logic                      slot_new, csr_wr, out_free, bin_ok;

   assign n_last   = CW'(cand_count_ff - NW'(1));
   assign slot_new = (slot_count_ff == '0);
   assign csr_wr   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_bin  = BW'((17'(req_payload.mz_value) + 17'd8) >> 4);
   assign bin_ok   = (bin_rdata_ff < binc_ff) && (bin_rdata_ff < BW'(sfcf_pkg::MAX_BINS));
   assign cur_idx  = slot_new ? CW'(cand_count_ff) : CW'(cand_count_ff - NW'(1));
   assign bin_waddr = AW'(cur_idx) * AW'(MZ) + AW'(SIW'(slot_count_ff));

   // read address selection
   always_comb begin
      head_raddr = '0;
      rank_raddr = '0;
      len_raddr  = '0;
      bin_raddr  = '0;
      unique case (state_ff)
         ST_RK_RDI:   head_raddr = ri_ff;
         ST_RK_RD:    head_raddr = rk_ff;
         ST_EM_RK:    head_raddr = rank_rdata_ff;
         ST_EM_TS:    head_raddr = em_cand_ff;
         ST_DR_RB:    rank_raddr = pi_ff;
         ST_DR_RA:    rank_raddr = pj_ff;
         ST_EM_CHK:   rank_raddr = pe_ff;
         ST_DR_LENBR: len_raddr  = cb_ff;
         ST_DR_LENAR: len_raddr  = ca_ff;
         ST_DR_BRD:   bin_raddr  = AW'(cb_ff) * AW'(MZ) + AW'(s_ff);
         ST_DR_ARD:   bin_raddr  = AW'(ca_ff) * AW'(MZ) + AW'(s_ff);
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      thr_in        = thr_ff;
      binc_in       = binc_ff;
      cand_count_in = cand_count_ff;
      slot_count_in = slot_count_ff;
      disc_in       = disc_ff;
      ovf_in        = ovf_ff;
      drop_in       = drop_ff;
      ri_in         = ri_ff;
      rk_in         = rk_ff;
      pos_in        = pos_ff;
      si_in         = si_ff;
      pi_in         = pi_ff;
      pj_in         = pj_ff;
      cb_in         = cb_ff;
      ca_in         = ca_ff;
      lenb_in       = lenb_ff;
      lena_in       = lena_ff;
      s_in          = s_ff;
      last_in       = last_ff;
      pe_in         = pe_ff;
      em_cand_in    = em_cand_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      head_we       = 1'b0;
      bin_we        = 1'b0;
      len_we        = 1'b0;
      rank_we       = 1'b0;
      ov_ctrl       = '0;

      if (csr_wr) begin
         unique case (csr_paddr[2])
            sfcf_pkg::REG_THRESHOLD: thr_in  = csr_pwdata[sfcf_pkg::THR_W-1:0];
            sfcf_pkg::REG_BIN_COUNT: binc_in = csr_pwdata[BW-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (slot_new) begin
                  if (cand_count_ff < NW'(MAX_CANDIDATES)) begin
                     disc_in       = 1'b0;
                     head_we       = 1'b1;
                     cand_count_in = cand_count_ff + NW'(1);
                  end else begin
                     disc_in = 1'b1;
                     ovf_in  = 1'b1;
                  end
               end
               if (slot_count_ff < SW'(MZ)) begin
                  bin_we        = !disc_in;
                  len_we        = !disc_in;
                  slot_count_in = slot_count_ff + SW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_payload.end_of_candidate || req_payload.end_of_scan) begin
                  slot_count_in = '0;
                  disc_in       = 1'b0;
               end
               if (req_payload.end_of_scan) begin
                  ri_in    = '0;
                  state_in = ST_RK_RDI;
               end
            end
         end
         ST_RK_RDI: state_in = ST_RK_LDI;
         ST_RK_LDI: begin
            si_in    = score_rdata_ff;
            rk_in    = '0;
            pos_in   = '0;
            state_in = ST_RK_RD;
         end
         ST_RK_RD: state_in = ST_RK_CMP;
         ST_RK_CMP: begin
            // stable descending rank: ties go to the earlier arrival
            if (($signed(score_rdata_ff) > $signed(si_ff)) ||
                ((score_rdata_ff == si_ff) && (rk_ff < ri_ff))) begin
               pos_in = pos_ff + CW'(1);
            end
            if (rk_ff == n_last) begin
               state_in = ST_RK_WR;
            end else begin
               rk_in    = rk_ff + CW'(1);
               state_in = ST_RK_RD;
            end
         end
         ST_RK_WR: begin
            rank_we = 1'b1;
            if (ri_ff == n_last) begin
               if (n_last == '0) begin
                  last_in  = n_last;
                  state_in = ST_LS;
               end else begin
                  pi_in    = CW'(1);
                  state_in = ST_DR_RB;
               end
            end else begin
               ri_in    = ri_ff + CW'(1);
               state_in = ST_RK_RDI;
            end
         end
         ST_DR_RB: state_in = ST_DR_LB;
         ST_DR_LB: begin
            cb_in    = rank_rdata_ff;
            state_in = ST_DR_LENBR;
         end
         ST_DR_LENBR: state_in = ST_DR_LENB;
         ST_DR_LENB: begin
            lenb_in  = len_rdata_ff;
            s_in     = '0;
            state_in = ST_DR_BRD;
         end
         ST_DR_BRD: begin
            if (s_ff == lenb_ff) begin
               pj_in    = '0;
               state_in = ST_DR_RA;
            end else begin
               state_in = ST_DR_BW;
            end
         end
         ST_DR_BW: begin
            ov_ctrl.load = 1'b1;
            s_in         = s_ff + SW'(1);
            state_in     = ST_DR_BRD;
         end
         ST_DR_RA: state_in = ST_DR_LA;
         ST_DR_LA: begin
            ca_in    = rank_rdata_ff;
            state_in = ST_DR_LENAR;
         end
         ST_DR_LENAR: state_in = ST_DR_LENA;
         ST_DR_LENA: begin
            lena_in       = len_rdata_ff;
            s_in          = '0;
            ov_ctrl.clear = 1'b1;
            state_in      = ST_DR_ARD;
         end
         ST_DR_ARD: begin
            if (s_ff == lena_ff) begin
               if (CMPW'(ov_count) >= CMPW'(thr_ff) || (pj_ff + CW'(1) == pi_ff)) begin
                  if (CMPW'(ov_count) >= CMPW'(thr_ff)) begin
                     drop_in[pi_ff] = 1'b1;
                  end
                  if (pi_ff == n_last) begin
                     last_in  = n_last;
                     state_in = ST_LS;
                  end else begin
                     pi_in    = pi_ff + CW'(1);
                     state_in = ST_DR_RB;
                  end
               end else begin
                  pj_in    = pj_ff + CW'(1);
                  state_in = ST_DR_RA;
               end
            end else begin
               state_in = ST_DR_AC;
            end
         end
         ST_DR_AC: begin
            ov_ctrl.check = bin_ok;
            s_in          = s_ff + SW'(1);
            state_in      = ST_DR_ARD;
         end
         ST_LS: begin
            // walk down to the lowest ranked kept candidate
            if (!drop_ff[last_ff] || (last_ff == '0)) begin
               pe_in    = '0;
               state_in = ST_EM_CHK;
            end else begin
               last_in = last_ff - CW'(1);
            end
         end
         ST_EM_CHK: begin
            if (drop_ff[pe_ff]) begin
               pe_in = pe_ff + CW'(1);
            end else begin
               state_in = ST_EM_RK;
            end
         end
         ST_EM_RK: begin
            em_cand_in = rank_rdata_ff;
            state_in   = ST_EM_TS;
         end
         ST_EM_TS: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kept_tag   = tag_rdata_ff;
               rsp_data_in.kept_score = score_rdata_ff;
               rsp_data_in.last_kept  = (pe_ff == last_ff);
               rsp_data_in.overflow   = ovf_ff;
               if (pe_ff == last_ff) begin
                  cand_count_in = '0;
                  slot_count_in = '0;
                  disc_in       = 1'b0;
                  ovf_in        = 1'b0;
                  drop_in       = '0;
                  state_in      = ST_LOAD;
               end else begin
                  pe_in    = pe_ff + CW'(1);
                  state_in = ST_EM_CHK;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         score_mem[CW'(cand_count_ff)] <= req_payload.score;
         tag_mem[CW'(cand_count_ff)]   <= req_payload.candidate_tag;
      end
      if (bin_we) begin
         bin_mem[bin_waddr] <= req_bin;
      end
      if (len_we) begin
         len_mem[cur_idx] <= slot_count_ff + SW'(1);
      end
      if (rank_we) begin
         rank_mem[pos_ff] <= ri_ff;
      end
      bin_rdata_ff   <= bin_mem[bin_raddr];
      score_rdata_ff <= score_mem[head_raddr];
      tag_rdata_ff   <= tag_mem[head_raddr];
      rank_rdata_ff  <= rank_mem[rank_raddr];
      len_rdata_ff   <= len_mem[len_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         thr_ff        <= sfcf_pkg::THRESHOLD_RESET;
         binc_ff       <= sfcf_pkg::BIN_COUNT_RESET;
         cand_count_ff <= '0;
         slot_count_ff <= '0;
         disc_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
         drop_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         thr_ff        <= thr_in;
         binc_ff       <= binc_in;
         cand_count_ff <= cand_count_in;
         slot_count_ff <= slot_count_in;
         disc_ff       <= disc_in;
         ovf_ff        <= ovf_in;
         drop_ff       <= drop_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ri_ff       <= ri_in;
      rk_ff       <= rk_in;
      pos_ff      <= pos_in;
      si_ff       <= si_in;
      pi_ff       <= pi_in;
      pj_ff       <= pj_in;
      cb_ff       <= cb_in;
      ca_ff       <= ca_in;
      lenb_ff     <= lenb_in;
      lena_ff     <= lena_in;
      s_ff        <= s_in;
      last_ff     <= last_in;
      pe_ff       <= pe_in;
      em_cand_ff  <= em_cand_in;
      rsp_data_ff <= rsp_data_in;
   end

   sfcf_overlap #(
      .MZ  (MZ),
      .SW  (SW),
      .SIW (SIW)
   ) u_overlap (
      .clock (clock),
      .reset (reset),
      .ctrl  (ov_ctrl),
      .slot  (SIW'(s_ff)),
      .bin   (bin_rdata_ff),
      .len_b (lenb_ff),
      .count (ov_count)
   );

   always_comb begin
      unique case (csr_paddr[2])
         sfcf_pkg::REG_THRESHOLD: csr_prdata = 32'(thr_ff);
         sfcf_pkg::REG_BIN_COUNT: csr_prdata = 32'(binc_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign csr_pready  = 1'b1;
   assign req_stall   = (state_ff != ST_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   property p_count_bounded;
      @(posedge clock) disable iff (reset) cand_count_ff <= NW'(MAX_CANDIDATES);
   endproperty
   a_count_bounded: assert property (p_count_bounded) else $error("candidate count overrun");

   property p_top_never_dropped;
      @(posedge clock) disable iff (reset) !drop_ff[0];
   endproperty
   a_top_never_dropped: assert property (p_top_never_dropped)
      else $error("first ranked candidate dropped");

   property p_rank_has_candidates;
      @(posedge clock) disable iff (reset) (state_ff == ST_RK_RDI) |-> (cand_count_ff != '0);
   endproperty
   a_rank_has_candidates: assert property (p_rank_has_candidates)
      else $error("ranking started on an empty scan");

   property p_slot_bounded;
      @(posedge clock) disable iff (reset) slot_count_ff <= SW'(MZ);
   endproperty
   a_slot_bounded: assert property (p_slot_bounded) else $error("slot count overrun");

endmodule

`default_nettype wire

/* tb/sv/tb_shared_fragment_candidate_filter.sv */
// Testbench for the shared fragment candidate filter: directed and random scans,
// checked against a behavioral scan filter. Depends on sfcf_pkg and the RTL top.
`timescale 1ns / 1ps

module tb_shared_fragment_candidate_filter;

   localparam int NCAND = 32;
   localparam int NMZ   = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   sfcf_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   sfcf_pkg::rsp_type rsp_payload;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   shared_fragment_candidate_filter dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // filter state mirror
   logic [3:0]                 thr_q;
   logic [sfcf_pkg::BIN_W-1:0] nbins_q;
   logic [12:0]                bins_q [NCAND][NMZ];
   int                         blen_q [NCAND];
   logic [31:0]                score_q [NCAND];
   logic [15:0]                tag_q [NCAND];
   int                         ncand_q, slot_q;
   bit                         ovf_q, skipping_q;
   sfcf_pkg::rsp_type          kept_expected [$];
   int                         fails = 0;

   function automatic bit bin_ok(logic [12:0] b);
      return b < nbins_q && b < sfcf_pkg::MAX_BINS;
   endfunction

   function automatic int overlap(int a, int b);
      int n = 0;
      bit dup, hit;
      for (int i = 0; i < blen_q[a]; i++) begin
         dup = 0; hit = 0;
         if (!bin_ok(bins_q[a][i])) continue;
         for (int j = 0; j < i; j++) if (bins_q[a][j] == bins_q[a][i]) dup = 1;
         if (dup) continue;
         for (int j = 0; j < blen_q[b]; j++) if (bins_q[b][j] == bins_q[a][i]) hit = 1;
         if (hit) n++;
      end
      return n;
   endfunction

   task automatic predict_filter(sfcf_pkg::req_type r);
      int rank [NCAND];
      bit dropped [NCAND];
      int k, last;
      sfcf_pkg::rsp_type o;
      if (slot_q == 0) begin
         if (ncand_q < NCAND) begin
            skipping_q = 0;
            tag_q[ncand_q] = r.candidate_tag;
            score_q[ncand_q] = r.score;
            blen_q[ncand_q] = 0;
            ncand_q++;
         end else begin
            skipping_q = 1; ovf_q = 1;
         end
      end
      if (slot_q < NMZ) begin
         if (!skipping_q) begin
            bins_q[ncand_q-1][slot_q] = 13'((17'(r.mz_value) + 17'd8) >> 4);
            blen_q[ncand_q-1] = slot_q + 1;
         end
         slot_q++;
      end else ovf_q = 1;
      if (r.end_of_candidate || r.end_of_scan) begin
         slot_q = 0; skipping_q = 0;
      end
      if (!r.end_of_scan) return;
      for (int i = 0; i < ncand_q; i++) begin
         k = i;
         while (k > 0 && $signed(score_q[rank[k-1]]) < $signed(score_q[i])) begin
            rank[k] = rank[k-1]; k--;
         end
         rank[k] = i;
         dropped[i] = 0;
      end
      for (int i = 1; i < ncand_q; i++)
         for (int j = 0; j < i && !dropped[i]; j++)
            if (overlap(rank[j], rank[i]) >= thr_q) dropped[i] = 1;
      last = 0;
      for (int i = 0; i < ncand_q; i++) if (!dropped[i]) last = i;
      for (int i = 0; i < ncand_q; i++) begin
         if (dropped[i]) continue;
         o.kept_tag = tag_q[rank[i]];
         o.kept_score = score_q[rank[i]];
         o.last_kept = (i == last);
         o.overflow = ovf_q;
         kept_expected = {kept_expected, o};
      end
      ncand_q = 0; slot_q = 0; ovf_q = 0; skipping_q = 0;
   endtask

   // valid stays up after acceptance until the next request or an idle gap
   task automatic send_request(sfcf_pkg::req_type r);
      int gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_filter(r);
   endtask

   task automatic write_reg(logic sel, logic [31:0] v);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {sel, 2'b00}; csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (sel == sfcf_pkg::REG_THRESHOLD) thr_q = v[3:0]; else nbins_q = v[12:0];
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (kept_expected.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // one candidate; bins drawn from a narrow window to force overlaps
   task automatic send_candidate(logic [15:0] tag, logic [31:0] sc, int nmz,
                                 int base, int spread, bit eos);
      sfcf_pkg::req_type r;
      for (int i = 0; i < nmz; i++) begin
         r.candidate_tag = (i == 0) ? tag : 16'($urandom);
         r.score = (i == 0) ? sc : $urandom;
         r.mz_value = 16'(((base + $urandom_range(0, spread)) << 4)
                          + $urandom_range(0, 15) - 8);
         if ($urandom_range(0, 9) == 0) r.mz_value = $urandom;
         r.end_of_candidate = (i == nmz - 1);
         r.end_of_scan = eos && (i == nmz - 1);
         send_request(r);
      end
   endtask

   task automatic random_scan(int ncand, int maxmz);
      for (int c = 0; c < ncand; c++)
         send_candidate($urandom, $urandom_range(0, 3) == 0 ? 32'(c % 3) : $urandom,
                        $urandom_range(1, maxmz), $urandom_range(0, 60), 12,
                        c == ncand - 1);
   endtask

   task automatic test_extremes();
      sfcf_pkg::req_type r;
      send_candidate(16'hFFFF, 32'h7FFFFFFF, 1, 0, 0, 0);
      send_candidate(16'h0000, 32'h80000000, 1, 0, 0, 0);
      r = '0; r.mz_value = 16'hFFFF; r.score = 32'h0; r.candidate_tag = 16'h5A5A;
      r.end_of_scan = 1'b1;   // scan end inside a candidate, no end_of_candidate
      send_request(r);
      send_candidate(16'h1234, 32'd5, 3, 100, 0, 1);   // single candidate, dup bins
      drain();
   endtask

   task automatic test_ties_and_threshold_zero();
      write_reg(sfcf_pkg::REG_THRESHOLD, 0);
      for (int c = 0; c < 4; c++) send_candidate(16'(c), 32'd7, 2, 500, 5, c == 3);
      drain();
      write_reg(sfcf_pkg::REG_THRESHOLD, 15);
      for (int c = 0; c < 3; c++) send_candidate(16'(c + 9), 32'd7, 12, 10, 14, c == 2);
      drain();
   endtask

   task automatic test_overflow();
      write_reg(sfcf_pkg::REG_THRESHOLD, 2);
      send_candidate(16'hAAAA, 32'd1, 15, 20, 20, 0);   // too many m/z
      send_candidate(16'hBBBB, 32'd2, 2, 20, 3, 1);
      drain();
      for (int c = 0; c < 34; c++) send_candidate(16'(c), $urandom, 1, 0, 40, c == 33);
      drain();
   endtask

   task automatic test_random();
      int limits [4] = '{0, 8191, 40, 4096};
      for (int s = 0; s < 28; s++) begin
         if (s % 7 == 0) begin
            write_reg(sfcf_pkg::REG_THRESHOLD,
                      $urandom_range(0, 15) % (s == 0 ? 16 : 5) + 1);
            write_reg(sfcf_pkg::REG_BIN_COUNT, limits[s / 7]);
         end
         random_scan($urandom_range(1, 5), 4);
         if (s % 7 == 6) drain();
      end
      write_reg(sfcf_pkg::REG_BIN_COUNT, 2048);
      write_reg(sfcf_pkg::REG_THRESHOLD, 1);
      drain();
   endtask

   // result checker with random stall
   initial begin
      int hold;
      sfcf_pkg::rsp_type e;
      forever begin
         hold = $urandom_range(0, 10);
         if ($urandom_range(0, 3) == 0) hold = 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         if (kept_expected.size() == 0) begin
            $error("unexpected result tag %h", rsp_payload.kept_tag);
            fails++;
         end else begin
            e = kept_expected.pop_front();
            if (rsp_payload.kept_tag !== e.kept_tag) begin
               $error("kept_tag expected %h got %h", e.kept_tag, rsp_payload.kept_tag);
               fails++;
            end
            if (rsp_payload.kept_score !== e.kept_score) begin
               $error("kept_score expected %h got %h", e.kept_score,
                      rsp_payload.kept_score);
               fails++;
            end
            if (rsp_payload.last_kept !== e.last_kept) begin
               $error("last_kept expected %b got %b", e.last_kept, rsp_payload.last_kept);
               fails++;
            end
            if (rsp_payload.overflow !== e.overflow) begin
               $error("overflow expected %b got %b", e.overflow, rsp_payload.overflow);
               fails++;
            end
         end
      end
   end

   initial begin
      thr_q = sfcf_pkg::THRESHOLD_RESET; nbins_q = sfcf_pkg::BIN_COUNT_RESET;
      ncand_q = 0; slot_q = 0; ovf_q = 0; skipping_q = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_ties_and_threshold_zero();
      test_overflow();
      test_random();
      if (fails == 0 && kept_expected.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
